// ----- src/lc2k_instruction_executor_unit_assert.svh -----
// Assertion macros used by the LC-2K controller.
`ifndef LC2K_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define LC2K_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LC2K_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LC2K_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- src/lc2k_pkg.sv -----
// Shared types, codes and constants of the LC-2K instruction executor.
package lc2k_pkg;

    // Default memory size in words.
    localparam int DEF_MEM_WORDS = 65536;

    // Width of the signed value that the address wrap unit reduces.
    localparam int XW = 34;

    // Request command codes.
    localparam logic [1:0] CMD_WRITE_MEM = 2'd0;
    localparam logic [1:0] CMD_STEP      = 2'd1;
    localparam logic [1:0] CMD_READ_MEM  = 2'd2;
    localparam logic [1:0] CMD_READ_REG  = 2'd3;

    // Instruction opcodes (bits 24..22).
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_NOR  = 3'd1;
    localparam logic [2:0] OP_LW   = 3'd2;
    localparam logic [2:0] OP_SW   = 3'd3;
    localparam logic [2:0] OP_BEQ  = 3'd4;
    localparam logic [2:0] OP_JALR = 3'd5;
    localparam logic [2:0] OP_HALT = 3'd6;
    localparam logic [2:0] OP_NOOP = 3'd7;

    // Input request payload.
    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        address;
        logic signed [31:0] data;
    } t_req;

    // Result payload.
    typedef struct packed {
        logic signed [31:0] read_data;
        logic [15:0]        program_counter;
        logic               halted;
        logic [2:0]         last_opcode;
    } t_resp;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INSTR,
        ST_REG_A,
        ST_REG_B,
        ST_EXEC,
        ST_WRAP_WAIT,
        ST_MEM_DATA,
        ST_REG_DATA,
        ST_RESP
    } t_state;

    // Source of the value handed to the address wrap unit.
    typedef enum logic [1:0] {
        WS_ADDR,
        WS_MEMEA,
        WS_BRANCH,
        WS_JALR
    } t_wsel;

    // Register file read address source.
    typedef enum logic [1:0] {
        RS_ADDR,
        RS_INSTR_A,
        RS_INSTR_B
    } t_rfrsel;

    // Register file write address and data source.
    typedef enum logic [1:0] {
        RW_ALU,
        RW_LOAD,
        RW_LINK
    } t_rfwsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    latch_instr;
        t_rfrsel rf_rsel;
        logic    latch_a;
        logic    latch_b;
        logic    report_op;
        logic    wrap_start;
        t_wsel   wrap_sel;
        logic    mem_write;
        logic    mem_read;
        logic    latch_mem_rd;
        logic    rf_write;
        t_rfwsel rf_wsel;
        logic    latch_rf_rd;
        logic    pc_load;
        logic    set_halt;
        logic    out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] opcode;
        logic       halted;
        logic       equal;
        logic       wrap_done;
    } t_ctl_stat;

endpackage

// ----- src/lc2k_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module lc2k_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/lc2k_wrap.sv -----
// Address wrap unit: reduces a signed value modulo the memory size.
module lc2k_wrap import lc2k_pkg::*; #(
    parameter int MEM_WORDS = DEF_MEM_WORDS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [XW-1:0]         i_value,
    output logic                         o_done,
    output logic [$clog2(MEM_WORDS)-1:0] o_result
);

    localparam int  AW      = $clog2(MEM_WORDS);
    localparam bit  IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic          r_done;
            logic [AW-1:0] r_res;

            // A power-of-two size keeps the low address bits.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else if (i_start) begin
                    r_done <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_res <= i_value[AW-1:0];
                end
            end

            assign o_done   = r_done;
            assign o_result = r_res;
        end else begin : g_recip
            localparam int RW = 33 - AW;
            localparam int PW = XW + RW;
            localparam int QW = PW - 32;
            // A multiple of the size that makes every value the datapath sends non-negative.
            localparam logic [XW-1:0] BIAS =
                XW'((((64'd1 << 32) / 64'(MEM_WORDS)) + 64'd1) * 64'(MEM_WORDS));
            // Truncated reciprocal; the estimated quotient is at most two short.
            localparam logic [RW-1:0] RECIP = RW'((64'd1 << 32) / 64'(MEM_WORDS));
            localparam logic [AW+1:0] M1    = (AW + 2)'(MEM_WORDS);
            localparam logic [AW+1:0] M2    = (AW + 2)'(2 * MEM_WORDS);

            logic [2:0]    r_stage;
            logic          r_done;
            logic [XW-1:0] r_y;
            logic [QW-1:0] r_q;
            logic [AW+1:0] r_r;
            logic [AW-1:0] r_res;
            logic [PW-1:0] prod;
            logic [XW-1:0] qm;
            logic [AW-1:0] n_res;

            // Quotient estimate from the reciprocal, then the partial remainder.
            assign prod = PW'(r_y) * PW'(RECIP);
            assign qm   = XW'(r_q) * XW'(MEM_WORDS);

            // The partial remainder is below three times the size.
            always_comb begin
                priority if (r_r >= M2) begin
                    n_res = AW'(r_r - M2);
                end else if (r_r >= M1) begin
                    n_res = AW'(r_r - M1);
                end else begin
                    n_res = r_r[AW-1:0];
                end
            end

            // Stage tracking: bias, estimate, partial remainder, correction.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= '0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= {r_stage[1:0], i_start};
                    if (i_start) begin
                        r_done <= 1'b0;
                    end else if (r_stage[2]) begin
                        r_done <= 1'b1;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_y <= XW'(i_value) + BIAS;
                end
                r_q <= prod[PW-1:32];
                r_r <= (AW + 2)'(r_y - qm);
                if (r_stage[2]) begin
                    r_res <= n_res;
                end
            end

            assign o_done   = r_done;
            assign o_result = r_res;
        end
    endgenerate

endmodule

// ----- src/lc2k_datapath.sv -----
// LC-2K datapath: memory, register file, pc, halt flag and result register.
module lc2k_datapath import lc2k_pkg::*; #(
    parameter int MEM_WORDS = DEF_MEM_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req      i_req,
    input  t_ctl_cmd  i_cmd,
    output t_ctl_stat o_stat,
    output t_resp     o_resp
);

    localparam int AW = $clog2(MEM_WORDS);

    // Request, instruction and operand registers.
    t_req               r_req;
    logic [31:0]        r_instr;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic [AW-1:0]      r_pc;
    logic               r_halt;
    logic [7:0]         r_rf_valid;
    logic               r_rf_rvalid;
    logic [31:0]        r_rdata;
    logic [2:0]         r_rep_op;
    t_resp              r_resp;

    logic [AW-1:0]      pc_inc;
    logic [AW-1:0]      wrap_res;
    logic               wrap_done;
    logic signed [XW-1:0] wrap_val;
    logic signed [XW-1:0] w_off;
    logic signed [XW-1:0] w_a;
    logic signed [XW-1:0] w_pc;
    logic signed [XW-1:0] w_addr;

    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_wdata;
    logic [31:0]        mem_q;
    logic [2:0]         rf_raddr;
    logic [2:0]         rf_waddr;
    logic [31:0]        rf_wdata;
    logic [31:0]        rf_q;
    logic [31:0]        rf_val;
    logic [2:0]         opcode;

    assign opcode = r_instr[24:22];

    // Incremented pc wraps at the memory size.
    assign pc_inc = (r_pc == AW'(MEM_WORDS - 1)) ? '0 : r_pc + AW'(1);

    // Operands for the address wrap unit.
    assign w_off  = XW'($signed(r_instr[15:0]));
    assign w_a    = XW'(r_a);
    assign w_pc   = XW'(r_pc);
    assign w_addr = XW'(r_req.address);

    always_comb begin
        unique case (i_cmd.wrap_sel)
            WS_MEMEA:  wrap_val = w_a + w_off;
            WS_BRANCH: wrap_val = w_pc + w_off;
            WS_JALR:   wrap_val = (r_instr[21:19] == r_instr[18:16]) ? w_pc : w_a;
            default:   wrap_val = w_addr;
        endcase
    end

    lc2k_wrap #(
        .MEM_WORDS (MEM_WORDS)
    ) u_wrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.wrap_start),
        .i_value  (wrap_val),
        .o_done   (wrap_done),
        .o_result (wrap_res)
    );

    // Unified memory: fetches read at the pc, data accesses at the wrapped address.
    assign mem_raddr = i_cmd.mem_read ? wrap_res : r_pc;
    assign mem_wdata = (r_req.command == CMD_WRITE_MEM) ? 32'(r_req.data) : 32'(r_b);

    lc2k_ram #(
        .WIDTH (32),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_write),
        .i_waddr (wrap_res),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // Register file read address.
    always_comb begin
        unique case (i_cmd.rf_rsel)
            RS_INSTR_A: rf_raddr = mem_q[21:19];
            RS_INSTR_B: rf_raddr = r_instr[18:16];
            default:    rf_raddr = r_req.address[2:0];
        endcase
    end

    // Register file write address and data.
    always_comb begin
        unique case (i_cmd.rf_wsel)
            RW_LOAD: begin
                rf_waddr = r_instr[18:16];
                rf_wdata = mem_q;
            end
            RW_LINK: begin
                rf_waddr = r_instr[18:16];
                rf_wdata = 32'(r_pc);
            end
            default: begin
                rf_waddr = r_instr[2:0];
                rf_wdata = (opcode == OP_ADD) ? 32'(r_a + r_b) : ~(r_a | r_b);
            end
        endcase
    end

    lc2k_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rf_write),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_q)
    );

    // A register never written since reset reads as zero.
    assign rf_val = r_rf_rvalid ? rf_q : '0;

    // Architectural control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_rf_valid  <= '0;
            r_rf_rvalid <= 1'b0;
        end else begin
            if (i_cmd.pc_load) begin
                r_pc <= wrap_res;
            end else if (i_cmd.latch_instr) begin
                r_pc <= pc_inc;
            end
            if (i_cmd.set_halt) begin
                r_halt <= 1'b1;
            end
            if (i_cmd.rf_write) begin
                r_rf_valid[rf_waddr] <= 1'b1;
            end
            r_rf_rvalid <= r_rf_valid[rf_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req    <= i_req;
            r_rdata  <= '0;
            r_rep_op <= '0;
        end
        if (i_cmd.latch_instr) begin
            r_instr <= mem_q;
        end
        if (i_cmd.latch_a) begin
            r_a <= rf_val;
        end
        if (i_cmd.latch_b) begin
            r_b <= rf_val;
        end
        if (i_cmd.report_op) begin
            r_rep_op <= opcode;
        end
        if (i_cmd.latch_mem_rd) begin
            r_rdata <= mem_q;
        end
        if (i_cmd.latch_rf_rd) begin
            r_rdata <= rf_val;
        end
        if (i_cmd.out_load) begin
            r_resp.read_data       <= r_rdata;
            r_resp.program_counter <= 16'(r_pc);
            r_resp.halted          <= r_halt;
            r_resp.last_opcode     <= r_rep_op;
        end
    end

    // Status toward the controller.
    assign o_stat.cmd       = r_req.command;
    assign o_stat.opcode    = opcode;
    assign o_stat.halted    = r_halt;
    assign o_stat.equal     = (r_a == r_b);
    assign o_stat.wrap_done = wrap_done;

    assign o_resp = r_resp;

endmodule

// ----- src/lc2k_controller.sv -----
// LC-2K controller: sequences each request through the datapath.
`include "lc2k_instruction_executor_unit_assert.svh"

module lc2k_controller import lc2k_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_STEP:     n_state = i_stat.halted ? ST_RESP : ST_INSTR;
                    CMD_READ_REG: n_state = ST_REG_DATA;
                    default:      n_state = ST_WRAP_WAIT;
                endcase
            end
            ST_INSTR: n_state = ST_REG_A;
            ST_REG_A: n_state = ST_REG_B;
            ST_REG_B: n_state = ST_EXEC;
            ST_EXEC: begin
                unique case (i_stat.opcode)
                    OP_LW, OP_SW, OP_JALR: n_state = ST_WRAP_WAIT;
                    OP_BEQ:  n_state = i_stat.equal ? ST_WRAP_WAIT : ST_RESP;
                    default: n_state = ST_RESP;
                endcase
            end
            ST_WRAP_WAIT: begin
                if (i_stat.wrap_done) begin
                    if (i_stat.cmd == CMD_READ_MEM ||
                        (i_stat.cmd == CMD_STEP && i_stat.opcode == OP_LW)) begin
                        n_state = ST_MEM_DATA;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_MEM_DATA: n_state = ST_RESP;
            ST_REG_DATA: n_state = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_req = i_valid;
            end
            ST_DECODE: begin
                // The memory reads at the pc and the register file at the
                // request address by default, so both results are ready next.
                if (i_stat.cmd == CMD_WRITE_MEM || i_stat.cmd == CMD_READ_MEM) begin
                    o_cmd.wrap_start = 1'b1;
                    o_cmd.wrap_sel   = WS_ADDR;
                end
            end
            ST_INSTR: begin
                o_cmd.latch_instr = 1'b1;
                o_cmd.rf_rsel     = RS_INSTR_A;
            end
            ST_REG_A: begin
                o_cmd.latch_a = 1'b1;
                o_cmd.rf_rsel = RS_INSTR_B;
            end
            ST_REG_B: begin
                o_cmd.latch_b = 1'b1;
            end
            ST_EXEC: begin
                o_cmd.report_op = 1'b1;
                unique case (i_stat.opcode)
                    OP_ADD, OP_NOR: begin
                        o_cmd.rf_write = 1'b1;
                        o_cmd.rf_wsel  = RW_ALU;
                    end
                    OP_LW, OP_SW: begin
                        o_cmd.wrap_start = 1'b1;
                        o_cmd.wrap_sel   = WS_MEMEA;
                    end
                    OP_BEQ: begin
                        o_cmd.wrap_start = i_stat.equal;
                        o_cmd.wrap_sel   = WS_BRANCH;
                    end
                    OP_JALR: begin
                        o_cmd.rf_write   = 1'b1;
                        o_cmd.rf_wsel    = RW_LINK;
                        o_cmd.wrap_start = 1'b1;
                        o_cmd.wrap_sel   = WS_JALR;
                    end
                    OP_HALT: begin
                        o_cmd.set_halt = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ST_WRAP_WAIT: begin
                if (i_stat.wrap_done) begin
                    unique case (i_stat.cmd)
                        CMD_WRITE_MEM: o_cmd.mem_write = 1'b1;
                        CMD_READ_MEM:  o_cmd.mem_read  = 1'b1;
                        default: begin
                            unique case (i_stat.opcode)
                                OP_SW:           o_cmd.mem_write = 1'b1;
                                OP_LW:           o_cmd.mem_read  = 1'b1;
                                OP_BEQ, OP_JALR: o_cmd.pc_load   = 1'b1;
                                default: begin
                                end
                            endcase
                        end
                    endcase
                end
            end
            ST_MEM_DATA: begin
                if (i_stat.cmd == CMD_STEP) begin
                    o_cmd.rf_write = 1'b1;
                    o_cmd.rf_wsel  = RW_LOAD;
                end else begin
                    o_cmd.latch_mem_rd = 1'b1;
                end
            end
            ST_REG_DATA: begin
                o_cmd.latch_rf_rd = 1'b1;
            end
            ST_RESP: begin
                o_cmd.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    // An accepted request always moves on to decode.
    `LC2K_ASSERT_NEXT(a_accept_decode, i_valid && !o_stall, r_state == ST_DECODE, "accept lost")
    // The pc only loads a finished wrapped address.
    `LC2K_ASSERT_IMPLY(a_pc_wrapped, o_cmd.pc_load, i_stat.wrap_done, "pc load before wrap")
    // Memory writes use a finished wrapped address.
    `LC2K_ASSERT_IMPLY(a_wr_wrapped, o_cmd.mem_write, i_stat.wrap_done, "write before wrap")
    // A waiting result is never overwritten.
    `LC2K_ASSERT_IMPLY(a_no_overwrite, o_cmd.out_load, !r_out_valid || !i_stall,
                       "result overwritten")

endmodule

// ----- src/lc2k_instruction_executor_unit.sv -----
// A register read passes decode and a register data state; a memory write waits for the address
// wrap, and a memory read then also reads the data. A step after a halt goes straight to the
// result; other steps fetch, read both registers and execute, then sw, jalr or a taken beq wait
// for the wrap and lw also reads the data. A new request is taken in the cycle after a result is
// loaded. A wrap keeps the low bits at a power-of-two size, else uses the remainder pipeline.
// Reset clears pc, halt flag and register valid bits at once; memory is undefined until written.
module lc2k_instruction_executor_unit import lc2k_pkg::*; #(
    parameter int MEM_WORDS = DEF_MEM_WORDS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_stall,
    output t_resp o_resp
);

    t_ctl_cmd  ctl_cmd;
    t_ctl_stat ctl_stat;

    // Request sequencing.
    lc2k_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (ctl_stat),
        .o_cmd   (ctl_cmd)
    );

    // Storage and execution.
    lc2k_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (ctl_cmd),
        .o_stat  (ctl_stat),
        .o_resp  (o_resp)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the LC-2K instruction executor unit.
`timescale 1ns / 1ps

module testbench;
    import lc2k_pkg::*;

    localparam int MEM_WORDS   = DEF_MEM_WORDS;
    localparam int N_RANDOM    = 650;
    localparam int CYCLE_LIMIT = 400000;

    // One row of the directed table: a request and, where typed, its result.
    typedef struct {
        t_req  req;
        bit    typed;
        t_resp exp;
    } t_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_req  i_req;
    logic  o_valid;
    logic  i_stall;
    t_resp o_resp;

    // Machine state as the bench predicts it.
    logic [31:0] mem_model [int];
    logic [31:0] rf_model [8];
    logic [15:0] pc_model;
    bit          halt_model;
    int          written_addrs [$];

    t_resp pending_status [$];
    t_row  dir_rows [$];
    int    fault_count;
    int    cycle_count;
    int    rcv_hold;
    bit    quiet;
    bit    halt_ok;

    lc2k_instruction_executor_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_resp  (o_resp)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Both sides draw a random idle gap per request, with no gap in quiet stretches.
    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [15:0] wrap_addr(longint a);
        longint m;
        m = a % MEM_WORDS;
        if (m < 0) m += MEM_WORDS;
        return m[15:0];
    endfunction

    function automatic logic [15:0] eff_addr(logic [2:0] ra, logic [15:0] off);
        return wrap_addr(longint'($signed(rf_model[ra])) + longint'($signed(off)));
    endfunction

    function automatic logic [31:0] load_word(logic [15:0] a);
        return mem_model.exists(int'(a)) ? mem_model[int'(a)] : 32'h0;
    endfunction

    function automatic void store_word(logic [15:0] a, logic [31:0] d);
        if (!mem_model.exists(int'(a))) written_addrs.push_back(int'(a));
        mem_model[int'(a)] = d;
    endfunction

    function automatic logic [31:0] enc(logic [2:0] op, logic [2:0] ra, logic [2:0] rb,
                                        logic [15:0] off);
        return {7'b0, op, ra, rb, off};
    endfunction

    function automatic t_req req_of(logic [1:0] c, logic [15:0] a, logic [31:0] d);
        t_req r;
        r.command = c;
        r.address = a;
        r.data    = d;
        return r;
    endfunction

    function automatic t_row row(logic [1:0] c, logic [15:0] a, logic [31:0] d,
                                 bit typed = 1'b0, logic [31:0] rd = '0);
        t_row r;
        r.req   = req_of(c, a, d);
        r.typed = typed;
        r.exp   = '0;
        r.exp.read_data = rd;
        return r;
    endfunction

    // Random instruction word; halt only once the closing sequence allows it.
    function automatic logic [31:0] random_instr();
        logic [2:0]  op;
        logic [15:0] off;
        op = 3'($urandom_range(0, 7));
        if (op == OP_HALT && !halt_ok) op = OP_NOOP;
        if ($urandom_range(0, 3) == 0) off = 16'($urandom);
        else off = 16'($urandom_range(0, 16) - 8);
        return {7'($urandom), op, 3'($urandom), 3'($urandom), off};
    endfunction

    // Applies one accepted request to the predicted state and returns its result.
    function automatic t_resp apply_request(t_req r);
        t_resp       res;
        logic [31:0] ins;
        logic [2:0]  op;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [15:0] off;
        res = '0;
        case (r.command)
            CMD_WRITE_MEM: store_word(wrap_addr(longint'(r.address)), r.data);
            CMD_STEP: begin
                if (!halt_model) begin
                    ins = load_word(pc_model);
                    op  = ins[24:22];
                    ra  = ins[21:19];
                    rb  = ins[18:16];
                    off = ins[15:0];
                    pc_model = wrap_addr(longint'(pc_model) + 1);
                    case (op)
                        OP_ADD:  rf_model[off[2:0]] = rf_model[ra] + rf_model[rb];
                        OP_NOR:  rf_model[off[2:0]] = ~(rf_model[ra] | rf_model[rb]);
                        OP_LW:   rf_model[rb] = load_word(eff_addr(ra, off));
                        OP_SW:   store_word(eff_addr(ra, off), rf_model[rb]);
                        OP_BEQ: begin
                            if (rf_model[ra] == rf_model[rb])
                                pc_model = wrap_addr(longint'(pc_model) +
                                                     longint'($signed(off)));
                        end
                        // The link is written before the target register is read.
                        OP_JALR: begin
                            rf_model[rb] = 32'(pc_model);
                            pc_model = wrap_addr(longint'($signed(rf_model[ra])));
                        end
                        OP_HALT: halt_model = 1'b1;
                        default: ;
                    endcase
                    res.last_opcode = op;
                end
            end
            CMD_READ_MEM: res.read_data = load_word(wrap_addr(longint'(r.address)));
            default: res.read_data = rf_model[r.address[2:0]];
        endcase
        res.program_counter = pc_model;
        res.halted          = halt_model;
        return res;
    endfunction

    // Offers one request, waits for it to be taken and records what it must return.
    task automatic send_request(input t_req r, input bit typed = 1'b0,
                                input t_resp typed_resp = '0);
        int    gap;
        t_resp predicted;
        gap = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = apply_request(r);
        pending_status.push_back(typed ? typed_resp : predicted);
    endtask

    // Makes sure the next fetch, and the word a load would read, have been written.
    task automatic step_program(output int issued);
        logic [31:0] ins;
        logic [15:0] ea;
        issued = 1;
        if (!mem_model.exists(int'(pc_model)) ||
            (mem_model[int'(pc_model)][24:22] == OP_HALT && !halt_ok)) begin
            send_request(req_of(CMD_WRITE_MEM, pc_model, random_instr()));
            issued++;
        end
        ins = mem_model[int'(pc_model)];
        if (ins[24:22] == OP_LW) begin
            ea = eff_addr(ins[21:19], ins[15:0]);
            if (!mem_model.exists(int'(ea))) begin
                send_request(req_of(CMD_WRITE_MEM, ea, $urandom));
                issued++;
            end
        end
        send_request(req_of(CMD_STEP, 16'($urandom), $urandom));
    endtask

    task automatic note_fault(input string what, input t_resp want, input t_resp got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t %s: expected rd=%h pc=%h halt=%b op=%0d, got rd=%h pc=%h halt=%b op=%0d",
                     $realtime, what, want.read_data, want.program_counter, want.halted,
                     want.last_opcode, got.read_data, got.program_counter, got.halted,
                     got.last_opcode);
    endtask

    // Result side: draw a stall length after each accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rcv_hold = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) rcv_hold = draw_wait();
            else if (rcv_hold != 0) rcv_hold--;
            i_stall <= (rcv_hold != 0);
        end
    end

    // Compare each accepted result with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_status.size() == 0) begin
                note_fault("unexpected result", '0, o_resp);
            end else begin
                want = pending_status.pop_front();
                if (want.read_data !== o_resp.read_data ||
                    want.program_counter !== o_resp.program_counter ||
                    want.halted !== o_resp.halted ||
                    want.last_opcode !== o_resp.last_opcode)
                    note_fault("result mismatch", want, o_resp);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int sent;
        int issued;
        int pick;
        int k;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        quiet       = 1'b0;
        halt_ok     = 1'b0;
        pc_model    = '0;
        halt_model  = 1'b0;
        foreach (rf_model[i]) rf_model[i] = '0;

        // Directed table: reset state, data extremes, every opcode but halt, wraps.
        dir_rows.push_back(row(CMD_READ_REG, 16'hFFFF, 32'h0, 1'b1, 32'h0));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'hFFFF, 32'h8000_0000, 1'b1));
        dir_rows.push_back(row(CMD_READ_MEM, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0000, 32'h7FFF_FFFF, 1'b1));
        dir_rows.push_back(row(CMD_READ_MEM, 16'h0000, 32'h0, 1'b1, 32'h7FFF_FFFF));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0000, enc(OP_LW, 3'd0, 3'd1, 16'hFFFF),
                               1'b1));
        dir_rows.push_back(row(CMD_STEP, 16'hFFFF, 32'hFFFF_FFFF));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0001, enc(OP_NOR, 3'd0, 3'd0, 16'hFFFA)));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0002, enc(OP_ADD, 3'd1, 3'd2, 16'h0003)));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0003, enc(OP_SW, 3'd0, 3'd3, 16'h7FFF)));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_READ_MEM, 16'h7FFF, 32'h0));
        // Taken branch with a negative offset that wraps below address zero.
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0004, enc(OP_BEQ, 3'd0, 3'd0, 16'hFFFA)));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0000, enc(OP_JALR, 3'd3, 3'd4, 16'h0)));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        // Jump and link through the same register, with the link wrapping to zero.
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'hFFFF, enc(OP_JALR, 3'd5, 3'd5, 16'h0)));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_WRITE_MEM, 16'h0000, 32'hFFFF_FFFF));
        dir_rows.push_back(row(CMD_STEP, 16'h0000, 32'h0));
        dir_rows.push_back(row(CMD_READ_REG, 16'h0004, 32'h0));
        dir_rows.push_back(row(CMD_READ_REG, 16'hFFFB, 32'h0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp);

        // Random part: mostly program execution over freshly written code.
        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 39) == 0) quiet = ~quiet;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                step_program(issued);
                sent += issued;
            end else begin
                if (pick < 60) begin
                    k = $urandom_range(0, 8);
                    send_request(req_of(CMD_WRITE_MEM, wrap_addr(longint'(pc_model) + k),
                                        random_instr()));
                end else if (pick < 68) begin
                    send_request(req_of(CMD_WRITE_MEM, 16'($urandom), $urandom));
                end else if (pick < 84) begin
                    k = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                    send_request(req_of(CMD_READ_MEM, k[15:0], $urandom));
                end else begin
                    send_request(req_of(CMD_READ_REG, 16'($urandom), $urandom));
                end
                sent++;
            end
        end

        // Halt is permanent, so it closes the run: then steps must change nothing.
        halt_ok = 1'b1;
        send_request(req_of(CMD_WRITE_MEM, pc_model,
                            {7'($urandom), OP_HALT, 3'($urandom), 3'($urandom),
                             16'($urandom)}));
        repeat (3) step_program(issued);
        send_request(req_of(CMD_WRITE_MEM, 16'h1234, $urandom));
        send_request(req_of(CMD_READ_MEM, 16'h1234, $urandom));
        send_request(req_of(CMD_READ_REG, 16'($urandom), $urandom));
        i_valid <= 1'b0;

        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/lc2k_pkg.sv
src/lc2k_ram.sv
src/lc2k_wrap.sv
src/lc2k_datapath.sv
src/lc2k_controller.sv
src/lc2k_instruction_executor_unit.sv
bench/testbench.sv
